FILE: rtl/core/adsf_pkg.sv
`default_nettype none
package adsf_pkg;

  localparam int SW = 20;
  localparam int MAX_WIDTH = 2048;

  typedef struct packed {
    logic signed [SW-1:0] sample_x;
    logic signed [SW-1:0] sample_y;
    logic signed [SW-1:0] sample_b;
  } in_item_t;

  typedef struct packed {
    logic signed [SW-1:0] out_x;
    logic signed [SW-1:0] out_y;
    logic signed [SW-1:0] out_b;
    logic [15:0]          out_row;
    logic [10:0]          out_col;
    logic                 frame_end;
  } out_item_t;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_INV_X  = 3'd2;
  localparam logic [2:0] REG_INV_Y  = 3'd3;
  localparam logic [2:0] REG_INV_B  = 3'd4;

  localparam logic [24:0] WT_SIDE   = 25'd3413348;
  localparam logic [24:0] WT_CORNER = 25'd561750;
  localparam logic [24:0] WT_CENTER = 25'd876824;

endpackage
`default_nettype wire

FILE: rtl/core/adaptive_dc_smoothing_filter.sv
`default_nettype none
// adaptive dc smoothing filter: takes a three-channel dc image in raster order, one item per
// pixel, and gives each interior pixel a weighted 3x3 smooth blended by a gap factor taken
// over all three channels; border pixels pass unchanged. rows r-2 and r-1 are held in one
// line memory with a registered read. items are taken one at a time: an interior item
// steps through accept, memory read and write-back, three smooth steps, four gap steps,
// one factor step, three blend steps, one emit step per result and one closing step; a
// border item goes from the memory step straight to the emit and closing steps. a result
// the receiver holds back keeps the item waiting in the emit state. the output
// register lets the next item start while the last result still waits. configuration is
// only taken while the block is idle.
module adaptive_dc_smoothing_filter
  import adsf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  typedef logic signed [SW-1:0] smp_t;
  typedef smp_t [2:0] pix_t;  // [0]=x [1]=y [2]=b

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SMOOTH, S_GAP, S_FACTOR, S_BLEND, S_EMIT
  } state_t;

  state_t state_r;

  logic [11:0] width_r;
  logic [15:0] height_r;
  logic [23:0] inv_r [3];
  logic [15:0] row_r;
  logic [10:0] col_r;

  // line memory: each word holds rows r-2 and r-1 of one column
  logic [6*SW-1:0] line_mem [MAX_WIDTH];
  logic [6*SW-1:0] line_rd_r;

  pix_t cur_r;
  pix_t win_r [3][2];  // [row top/mid/bot][c-1, c-2]
  logic [15:0] r_r;
  logic [10:0] c_r;
  logic        last_col_r, last_row_r;

  // smooth pipeline state
  logic [1:0] ch_r;
  logic signed [SW+23+8:0] acc_r [3];
  logic signed [SW+17:0]   diff_r [3];
  logic [32:0] gap_r;
  logic [21:0] factor_r;
  pix_t res_r;

  // emission list
  logic [2:0] emit_r;  // pending results, bit0 first
  out_item_t out_r;
  logic      out_valid_r;
  logic      emit_go;

  // effective geometry
  logic [CW-1:0] w_eff;
  logic [15:0]   h_eff;
  always_comb begin
    if (width_r == 12'd0) w_eff = CW'(1);
    else if ({20'd0, width_r} > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_r);
    h_eff = (height_r == 16'd0) ? 16'd1 : height_r;
  end

  logic [15:0] r_sat;
  logic [10:0] c_sat;
  always_comb begin
    r_sat = (row_r < h_eff) ? row_r : h_eff - 16'd1;
    c_sat = ({{(32-11){1'b0}}, col_r} < 32'(w_eff)) ? col_r : 11'(w_eff - CW'(1));
  end

  pix_t top_p, mid_p;
  assign top_p = line_rd_r[6*SW-1:3*SW];
  assign mid_p = line_rd_r[3*SW-1:0];

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a result moves into the output register this cycle
  assign emit_go = (state_r == S_EMIT) && (emit_r != 3'b000) && (!out_valid_r || out_ready);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd2048;
      height_r <= 16'd1;
      inv_r[0] <= 24'd65536;
      inv_r[1] <= 24'd65536;
      inv_r[2] <= 24'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[11:0];
        REG_HEIGHT: height_r <= cfg_data[15:0];
        REG_INV_X:  inv_r[0] <= cfg_data[23:0];
        REG_INV_Y:  inv_r[1] <= cfg_data[23:0];
        REG_INV_B:  inv_r[2] <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // memory: read on accept, write back when the item leaves S_READ
  always_ff @(posedge clk) begin
    if (in_valid && in_ready)
      line_rd_r <= line_mem[AW'(c_sat)];
    if (state_r == S_READ)
      line_mem[AW'(c_r)] <= {mid_p, cur_r};
  end

  // per-channel arithmetic, one channel per cycle on a shared unit
  logic signed [SW+3:0] corner_s, side_s;
  smp_t cc;
  logic signed [SW+23+8:0] acc_n;
  always_comb begin
    corner_s = (SW+4)'(win_r[0][1][ch_r]) + (SW+4)'(top_p[ch_r])
             + (SW+4)'(win_r[2][1][ch_r]) + (SW+4)'(cur_r[ch_r]);
    side_s   = (SW+4)'(win_r[1][1][ch_r]) + (SW+4)'(mid_p[ch_r])
             + (SW+4)'(win_r[0][0][ch_r]) + (SW+4)'(win_r[2][0][ch_r]);
    cc       = win_r[1][0][ch_r];
    acc_n = $signed({1'b0, WT_CORNER}) * corner_s + $signed({1'b0, WT_SIDE}) * side_s
          + $signed({1'b0, WT_CENTER}) * cc;
  end

  // gap steps: diff of channel dch is formed while the gap of channel gch is taken
  logic [1:0] dch, gch;
  assign dch = (ch_r == 2'd3) ? 2'd2 : ch_r;
  assign gch = (ch_r == 2'd0) ? 2'd0 : ch_r - 2'd1;

  // diff = round(acc/2^16) - center*256
  logic signed [SW+17:0] diff_n;
  logic [SW+17:0] ad;
  logic [32:0] ad_c;
  logic [56:0] g_n;
  always_comb begin
    diff_n = (SW+18)'((acc_r[dch] + (SW+32)'(32768)) >>> 16)
           - ((SW+18)'(win_r[1][0][dch]) <<< 8);
    ad   = diff_r[gch][SW+17] ? (SW+18)'(-diff_r[gch]) : diff_r[gch];
    ad_c = ({{(57-SW-18){1'b0}}, ad} > 57'h1_0000_0000) ? 33'h1_0000_0000 : 33'(ad);
    g_n  = 57'(ad_c) * 57'(inv_r[gch]);
  end

  logic signed [SW+41:0] prod;
  logic signed [SW+13:0] rnd;
  logic signed [SW+14:0] sum;
  smp_t res_n;
  always_comb begin
    prod = (SW+42)'(diff_r[ch_r]) * $signed({1'b0, factor_r});
    rnd  = (SW+14)'((prod + (SW+42)'(1 << 27)) >>> 28);
    sum  = (SW+15)'(win_r[1][0][ch_r]) + (SW+15)'(rnd);
    if (sum > (SW+15)'((1 << (SW-1)) - 1)) res_n = smp_t'((1 << (SW-1)) - 1);
    else if (sum < -(SW+15)'(1 << (SW-1))) res_n = smp_t'(-(1 << (SW-1)));
    else res_n = smp_t'(sum);
  end

  // four times gap, rounded to the factor's 20 fraction bits
  logic [34:0] f4;
  always_comb f4 = ({gap_r, 2'b00} + 35'd2048) >> 12;

  logic interior;
  assign interior = (r_r >= 16'd2) && (c_r >= 11'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
      emit_r      <= '0;
      ch_r        <= '0;
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= '0;
        win_r[i][1] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready && !emit_go) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cur_r      <= {in_data.sample_b, in_data.sample_y, in_data.sample_x};
            r_r        <= r_sat;
            c_r        <= c_sat;
            last_col_r <= ({{(32-11){1'b0}}, c_sat} == 32'(w_eff) - 32'd1);
            last_row_r <= (r_sat == h_eff - 16'd1);
            if ({{(32-11){1'b0}}, c_sat} + 32'd1 < 32'(w_eff)) begin
              col_r <= c_sat + 11'd1;
              row_r <= r_sat;
            end else begin
              col_r <= '0;
              row_r <= (r_sat + 16'd1 < h_eff) ? r_sat + 16'd1 : 16'd0;
            end
            state_r <= S_READ;
          end
        end
        S_READ: begin
          emit_r  <= {last_row_r, (r_r >= 16'd1) && last_col_r,
                      (r_r >= 16'd1) && (c_r >= 11'd1)};
          ch_r    <= '0;
          gap_r   <= 33'h0_8000_0000;
          res_r   <= win_r[1][0];
          state_r <= interior ? S_SMOOTH : S_EMIT;
        end
        S_SMOOTH: begin
          acc_r[ch_r] <= acc_n;
          if (ch_r == 2'd2) begin ch_r <= '0; state_r <= S_GAP; end
          else ch_r <= ch_r + 2'd1;
        end
        S_GAP: begin
          if (ch_r != 2'd3) diff_r[dch] <= diff_n;
          if (ch_r != 2'd0 && g_n > 57'(gap_r))
            gap_r <= (g_n > 57'h1_0000_0000) ? 33'h1_0000_0000 : 33'(g_n);
          if (ch_r == 2'd3) begin
            ch_r    <= '0;
            state_r <= S_FACTOR;
          end else ch_r <= ch_r + 2'd1;
        end
        S_FACTOR: begin
          // factor = max(0, 3 - 4*gap), gap has settled
          factor_r <= (f4 >= 35'd3145728) ? 22'd0 : 22'(35'd3145728 - f4);
          state_r  <= S_BLEND;
        end
        S_BLEND: begin
          res_r[ch_r] <= res_n;
          if (ch_r == 2'd2) state_r <= S_EMIT;
          else ch_r <= ch_r + 2'd1;
        end
        S_EMIT: begin
          if (emit_r == 3'b000) begin
            // all results handed over, shift the window and take the next item
            for (int i = 0; i < 3; i++) win_r[i][1] <= win_r[i][0];
            win_r[0][0] <= top_p;
            win_r[1][0] <= mid_p;
            win_r[2][0] <= cur_r;
            state_r <= S_IDLE;
          end else if (!out_valid_r || out_ready) begin
            if (emit_r[0]) begin
              out_r <= '{out_x: res_r[0], out_y: res_r[1], out_b: res_r[2],
                         out_row: r_r - 16'd1, out_col: c_r - 11'd1, frame_end: 1'b0};
              out_valid_r <= 1'b1;
              emit_r[0] <= 1'b0;
            end else if (emit_r[1]) begin
              out_r <= '{out_x: mid_p[0], out_y: mid_p[1], out_b: mid_p[2],
                         out_row: r_r - 16'd1, out_col: c_r, frame_end: 1'b0};
              out_valid_r <= 1'b1;
              emit_r[1] <= 1'b0;
            end else begin
              out_r <= '{out_x: cur_r[0], out_y: cur_r[1], out_b: cur_r[2],
                         out_row: r_r, out_col: c_r, frame_end: last_col_r};
              out_valid_r <= 1'b1;
              emit_r[2] <= 1'b0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> emit_r == 3'b000)
    else $error("item taken with results pending");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && emit_r[0] |-> c_r != 11'd0)
    else $error("interior result at column zero");

endmodule
`default_nettype wire
